// ===== rtl/dots_pkg.sv =====
// ----------------------------------------------------------------------------
// dots_pkg
// Shared types and constants for the DHCP option record scanner.
// ----------------------------------------------------------------------------
package dots_pkg;

    localparam logic [7:0] TARGET_CODE_RESET = 8'd53;
    localparam logic [3:0] MAX_OPTIONS_RESET = 4'd10;

    // Register indexes on the configuration port.
    localparam logic REG_TARGET_CODE = 1'b0;
    localparam logic REG_MAX_OPTIONS = 1'b1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef struct packed {
        logic [7:0]  option_byte;
        logic        first;
        logic [10:0] area_length;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] value_length;
        logic [7:0] first_value;
    } out_item_t;

    typedef struct packed {
        logic [7:0] target_code;
        logic [3:0] max_options;
    } cfg_t;

    typedef enum logic [3:0] {
        PH_DONE = 4'b0001,
        PH_CODE = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_VAL  = 4'b1000
    } phase_t;

endpackage

// ===== rtl/dhcp_option_tlv_scanner.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_tlv_scanner
// Walks the DHCP options area byte by byte and reports the configured option.
// ----------------------------------------------------------------------------
// Bytes of the options area enter on the s_ channel, one per transaction; a
// byte with first set starts a new search and carries its byte budget. The
// first byte is also the first record's code byte. Each search ends with one
// transaction on the m_ channel: found, the option's length and its first
// value byte, or all zero when the option is absent. Bytes after the end of a
// search produce nothing until the next first byte.
// The deciding byte's result is written into the result register, which
// drives m_valid. Throughput is one byte per cycle unless a result waits on
// a stalled receiver: a byte passes through an input register, the record
// walk logic and the result register, and the input register refills in
// the cycle it drains. On such a stall the result register holds; the input
// register takes a byte only if empty, then s_ready is low until m_ready.
// Reset clears the search (no search active), empties both registers and
// loads target_code 53 and max_options 10. Both registers are written over
// the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module dhcp_option_tlv_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dots_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dots_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dots_pkg::PADDR_W-1:0]  paddr,
    input  logic [dots_pkg::PDATA_W-1:0]  pwdata,
    output logic [dots_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    dots_pkg::cfg_t      cfg;
    dots_pkg::in_item_t  in_data_reg;
    dots_pkg::out_item_t out_data_reg;
    dots_pkg::out_item_t result;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                advance;
    logic                fire;
    logic                emit;

    dots_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The byte in the input register moves on whenever the result register
    // is free or being emptied this cycle.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    dots_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .emit    (emit),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (emit) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/dots_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dots_cfg_regs
// APB register file holding the searched option code and the record limit.
// ----------------------------------------------------------------------------
module dots_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dots_pkg::PADDR_W-1:0]  paddr,
    input  logic [dots_pkg::PDATA_W-1:0]  pwdata,
    output logic [dots_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output dots_pkg::cfg_t                cfg
);

    logic [7:0] target_code_reg;
    logic [3:0] max_options_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_code_reg <= dots_pkg::TARGET_CODE_RESET;
            max_options_reg <= dots_pkg::MAX_OPTIONS_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                dots_pkg::REG_TARGET_CODE: target_code_reg <= pwdata[7:0];
                dots_pkg::REG_MAX_OPTIONS: max_options_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            dots_pkg::REG_TARGET_CODE: prdata[7:0] = target_code_reg;
            dots_pkg::REG_MAX_OPTIONS: prdata[3:0] = max_options_reg;
            default: prdata = '0;
        endcase
    end

    assign cfg.target_code = target_code_reg;
    assign cfg.max_options = max_options_reg;

endmodule

// ===== rtl/dots_step.sv =====
// ----------------------------------------------------------------------------
// dots_step
// Search state and the per-byte record walk; one byte is consumed per fire.
// ----------------------------------------------------------------------------
module dots_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  dots_pkg::in_item_t  item,
    input  dots_pkg::cfg_t      cfg,
    output logic                emit,
    output dots_pkg::out_item_t result
);

    dots_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [10:0] budget_reg, budget_next, budget_eff;
    logic [3:0]  recs_reg, recs_next, recs_eff, recs_inc;
    logic [7:0]  skip_reg, skip_next, skip_eff, skip_dec;
    logic        match_reg, match_next, match_eff;
    logic [7:0]  slen_reg, slen_next;
    logic [8:0]  need;
    logic [10:0] budget_sub;
    logic [7:0]  b;

    assign b          = item.option_byte;
    assign need       = 9'd2 + {1'b0, b};
    assign budget_sub = budget_eff - {2'b00, need};
    assign recs_inc   = recs_eff + 4'd1;
    assign skip_dec   = skip_eff - 8'd1;

    always_comb begin
        phase_eff  = phase_reg;
        budget_eff = budget_reg;
        recs_eff   = recs_reg;
        skip_eff   = skip_reg;
        match_eff  = match_reg;
        slen_next  = slen_reg;
        emit       = 1'b0;
        result     = '0;
        if (item.first) begin
            budget_eff = item.area_length;
            recs_eff   = 4'd0;
            skip_eff   = 8'd0;
            match_eff  = 1'b0;
            slen_next  = 8'd0;
            // An empty budget or a zero record limit ends the search at once.
            if (item.area_length == 11'd0 || cfg.max_options == 4'd0) begin
                emit      = 1'b1;
                phase_eff = dots_pkg::PH_DONE;
            end else begin
                phase_eff = dots_pkg::PH_CODE;
            end
        end
        phase_next  = phase_eff;
        budget_next = budget_eff;
        recs_next   = recs_eff;
        skip_next   = skip_eff;
        match_next  = match_eff;
        if (!emit) begin
            unique case (phase_eff)
                dots_pkg::PH_CODE: begin
                    match_next = (b == cfg.target_code);
                    phase_next = dots_pkg::PH_LEN;
                end
                dots_pkg::PH_LEN: begin
                    slen_next = b;
                    if (match_eff) begin
                        if (b == 8'd0) begin
                            emit         = 1'b1;
                            result.found = 1'b1;
                            phase_next   = dots_pkg::PH_DONE;
                        end else begin
                            phase_next = dots_pkg::PH_VAL;
                        end
                    end else if ({2'b00, need} > budget_eff) begin
                        emit       = 1'b1;
                        phase_next = dots_pkg::PH_DONE;
                    end else begin
                        budget_next = budget_sub;
                        recs_next   = recs_inc;
                        if (budget_sub == 11'd0 || recs_inc >= cfg.max_options) begin
                            emit       = 1'b1;
                            phase_next = dots_pkg::PH_DONE;
                        end else if (b == 8'd0) begin
                            phase_next = dots_pkg::PH_CODE;
                        end else begin
                            skip_next  = b;
                            phase_next = dots_pkg::PH_VAL;
                        end
                    end
                end
                dots_pkg::PH_VAL: begin
                    if (match_eff) begin
                        emit                = 1'b1;
                        result.found        = 1'b1;
                        result.value_length = slen_reg;
                        result.first_value  = b;
                        phase_next          = dots_pkg::PH_DONE;
                    end else begin
                        skip_next = skip_dec;
                        if (skip_dec == 8'd0) begin
                            phase_next = dots_pkg::PH_CODE;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (!fire) begin
            emit = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= dots_pkg::PH_DONE;
            budget_reg <= '0;
            recs_reg   <= '0;
            skip_reg   <= '0;
            match_reg  <= 1'b0;
            slen_reg   <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            budget_reg <= budget_next;
            recs_reg   <= recs_next;
            skip_reg   <= skip_next;
            match_reg  <= match_next;
            slen_reg   <= slen_next;
        end
    end

`ifndef ASSERT_OFF
    a_empty_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.first && item.area_length == 11'd0 |-> emit && !result.found)
        else $error("empty budget did not end the search");

    a_found_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && result.found |-> match_reg && !item.first)
        else $error("found reported without a matching code");

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.first && phase_reg == dots_pkg::PH_DONE |-> !emit)
        else $error("result emitted while no search is active");

    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !result.found |-> result.value_length == 8'd0 &&
        result.first_value == 8'd0)
        else $error("absent option carries nonzero fields");
`endif

endmodule

// ===== sim/dhcp_option_tlv_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_tlv_scanner_tb
// Self-checking bench for the DHCP option record scanner.
// ----------------------------------------------------------------------------
// Option bytes are streamed in as packets of code/length/value records with
// random content and budgets. A scoreboard keeps its own walk of the records
// and predicts each search result, which is then checked against the result
// channel. Both sides idle at random and the receiver holds off once for a
// long stretch. Both configuration registers are rewritten between phases.
// ----------------------------------------------------------------------------
package scan_check_pkg;
    import dots_pkg::*;

    class option_scoreboard;
        logic [7:0]  target_code;
        logic [3:0]  max_options;
        phase_t      walk_phase;
        logic [10:0] budget_left;
        logic [3:0]  records_seen;
        logic [7:0]  skip_left;
        logic        code_hit;
        logic [7:0]  held_length;
        out_item_t   expected_q[$];
        int unsigned n_results;
        int unsigned n_found;
        int unsigned n_errors;

        function new();
            target_code  = TARGET_CODE_RESET;
            max_options  = MAX_OPTIONS_RESET;
            walk_phase   = PH_DONE;
            budget_left  = '0;
            records_seen = '0;
            skip_left    = '0;
            code_hit     = 1'b0;
            held_length  = '0;
            n_results    = 0;
            n_found      = 0;
            n_errors     = 0;
        endfunction

        function void flag_error(string msg);
            n_errors++;
            if (n_errors <= 10) begin
                $display("MISMATCH: %s", msg);
            end
        endfunction

        function void finish_search(logic hit, logic [7:0] len, logic [7:0] val);
            out_item_t r;
            r.found        = hit;
            r.value_length = len;
            r.first_value  = val;
            expected_q.push_back(r);
            walk_phase = PH_DONE;
        endfunction

        // Advances the record walk by one accepted option byte.
        function void note_byte(in_item_t it);
            logic [8:0] need;
            need = 9'd2 + {1'b0, it.option_byte};
            if (it.first) begin
                budget_left  = it.area_length;
                records_seen = '0;
                skip_left    = '0;
                code_hit     = 1'b0;
                held_length  = '0;
                if (budget_left == 0 || max_options == 0) begin
                    finish_search(1'b0, 8'd0, 8'd0);
                    return;
                end
                walk_phase = PH_CODE;
            end
            case (walk_phase)
                PH_CODE: begin
                    code_hit   = (it.option_byte == target_code);
                    walk_phase = PH_LEN;
                end
                PH_LEN: begin
                    held_length = it.option_byte;
                    if (code_hit) begin
                        if (it.option_byte == 0) begin
                            finish_search(1'b1, 8'd0, 8'd0);
                        end else begin
                            walk_phase = PH_VAL;
                        end
                    end else if ({2'b00, need} > budget_left) begin
                        finish_search(1'b0, 8'd0, 8'd0);
                    end else begin
                        // A skipped record is charged in full on its length byte.
                        budget_left  = budget_left - {2'b00, need};
                        records_seen = records_seen + 4'd1;
                        if (budget_left == 0 || records_seen >= max_options) begin
                            finish_search(1'b0, 8'd0, 8'd0);
                        end else if (it.option_byte == 0) begin
                            walk_phase = PH_CODE;
                        end else begin
                            skip_left  = it.option_byte;
                            walk_phase = PH_VAL;
                        end
                    end
                end
                PH_VAL: begin
                    if (code_hit) begin
                        finish_search(1'b1, held_length, it.option_byte);
                    end else begin
                        skip_left = skip_left - 8'd1;
                        if (skip_left == 0) begin
                            walk_phase = PH_CODE;
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                flag_error($sformatf("unexpected result found=%0d length=%0d value=0x%02h",
                                     got.found, got.value_length, got.first_value));
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            if (want.found) begin
                n_found++;
            end
            if (got.found !== want.found || got.value_length !== want.value_length ||
                got.first_value !== want.first_value) begin
                flag_error($sformatf(
                    "expected found=%0d length=%0d value=0x%02h, got found=%0d length=%0d value=0x%02h",
                    want.found, want.value_length, want.first_value,
                    got.found, got.value_length, got.first_value));
            end
        endfunction
    endclass
endpackage

module dhcp_option_tlv_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dots_pkg::*;
    import scan_check_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    option_scoreboard sb;

    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int          rx_hold_req  = 0;
    int          rx_hold_left = 0;
    int unsigned cycle_count  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned packets_sent = 0;

    dhcp_option_tlv_scanner DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dhcp_option_tlv_scanner_tb: errors");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= !rx_idle_on || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if (s_valid && s_ready) begin
                sb.note_byte(s_data);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic is_first, logic [10:0] alen);
        in_item_t it;
        it.option_byte = b;
        it.first       = is_first;
        it.area_length = alen;
        while (tx_idle_on && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        bytes_sent++;
    endtask

    // Waits until every search result has been taken and the pipeline is empty.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(logic wr, logic idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        rdata = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] mask;
        apb_access(1'b1, idx, value, rd);
        if (idx == REG_TARGET_CODE) begin
            sb.target_code = value[7:0];
            mask = 32'h0000_00FF;
        end else begin
            sb.max_options = value[3:0];
            mask = 32'h0000_000F;
        end
        apb_access(1'b0, idx, 32'd0, rd);
        if ((rd & mask) !== (value & mask)) begin
            sb.flag_error($sformatf("register %0d reads 0x%0h after writing 0x%0h",
                                    idx, rd, value));
        end
    endtask

    // Appends one code/length/value record; lengths are mostly short.
    function automatic void append_record(ref logic [7:0] rec_q[$], input logic [7:0] code);
        int pick;
        int len;
        pick = $urandom_range(63);
        if (pick < 12) begin
            len = 0;
        end else if (pick < 58) begin
            len = $urandom_range(1, 6);
        end else if (pick < 63) begin
            len = $urandom_range(7, 40);
        end else begin
            len = $urandom_range(41, 255);
        end
        rec_q.push_back(code);
        rec_q.push_back(len[7:0]);
        for (int i = 0; i < len; i++) begin
            rec_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic send_packet();
        logic [7:0] rec_q[$];
        logic [7:0] code;
        int         n_other;
        int         sz;
        int         budget;
        int         cut;
        n_other = $urandom_range(sb.max_options + 1);
        for (int i = 0; i < n_other; i++) begin
            code = 8'($urandom_range(255));
            if (code == sb.target_code) begin
                code = code + 8'd1;
            end
            append_record(rec_q, code);
        end
        if ($urandom_range(3) != 0 || rec_q.size() == 0) begin
            append_record(rec_q, sb.target_code);
        end
        sz = rec_q.size();
        case ($urandom_range(7))
            0, 1, 2, 3: budget = sz + $urandom_range(3);
            4:          budget = $urandom_range(sz);
            5:          budget = 2047;
            default:    budget = $urandom_range(2047);
        endcase
        if (budget > 2047) begin
            budget = 2047;
        end
        // Some packets are cut short so that the next one restarts the search.
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, sz) : sz;
        send_byte(rec_q[0], 1'b1, budget[10:0]);
        for (int i = 1; i < cut; i++) begin
            send_byte(rec_q[i], 1'b0, 11'($urandom_range(2047)));
        end
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0,
                                                    11'($urandom_range(2047)));
        end
        packets_sent++;
    endtask

    task automatic run_random(int n_bytes);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            send_packet();
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An empty budget ends the search at once, then an idle byte.
        send_byte(8'd53, 1'b1, 11'd0);
        send_byte(8'hFF, 1'b0, 11'h7FF);
        // Matching option of length zero.
        send_byte(8'd53, 1'b1, 11'd2);
        send_byte(8'd0, 1'b0, 11'd0);
        // Longest match with the largest budget.
        send_byte(8'd53, 1'b1, 11'd2047);
        send_byte(8'd255, 1'b0, 11'd0);
        send_byte(8'hAB, 1'b0, 11'd0);
        // Budget used up exactly by a skipped record.
        send_byte(8'd1, 1'b1, 11'd3);
        send_byte(8'd1, 1'b0, 11'd0);
        send_byte(8'h77, 1'b0, 11'd0);
        // Record longer than the remaining budget.
        send_byte(8'd7, 1'b1, 11'd2);
        send_byte(8'd1, 1'b0, 11'd0);
        // A new first byte abandons the search in progress.
        send_byte(8'd9, 1'b1, 11'd100);
        send_byte(8'd2, 1'b0, 11'd0);
        send_byte(8'h11, 1'b0, 11'd0);
        send_byte(8'd53, 1'b1, 11'd10);
        send_byte(8'd1, 1'b0, 11'd0);
        send_byte(8'h00, 1'b0, 11'd0);
        // Skip one record, then find the target.
        send_byte(8'd0, 1'b1, 11'd20);
        send_byte(8'd1, 1'b0, 11'd0);
        send_byte(8'h5A, 1'b0, 11'd0);
        send_byte(8'd53, 1'b0, 11'd0);
        send_byte(8'd2, 1'b0, 11'd0);
        send_byte(8'hC3, 1'b0, 11'd0);
        send_byte(8'h3C, 1'b0, 11'd0);
        run_random(360);
        drain();

        write_reg(REG_TARGET_CODE, 32'd0);
        write_reg(REG_MAX_OPTIONS, 32'd1);
        // One skipped record already reaches the record limit.
        send_byte(8'd2, 1'b1, 11'd50);
        send_byte(8'd0, 1'b0, 11'd0);
        run_random(180);
        drain();

        write_reg(REG_TARGET_CODE, 32'd255);
        write_reg(REG_MAX_OPTIONS, 32'd15);
        rx_hold_req = 400;
        run_random(280);
        drain();

        // With no records allowed, every first byte ends its search at once.
        write_reg(REG_MAX_OPTIONS, 32'd0);
        run_random(30);
        drain();

        for (int k = 0; k < 2; k++) begin
            write_reg(REG_TARGET_CODE, $urandom_range(255));
            write_reg(REG_MAX_OPTIONS, $urandom_range(1, 15));
            tx_idle_on = (k == 0);
            rx_idle_on = (k == 0);
            run_random(200);
            drain();
        end

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_reg(REG_TARGET_CODE, 32'd53);
        write_reg(REG_MAX_OPTIONS, 32'd10);
        run_random(200);
        drain();

        if (sb.expected_q.size() != 0) begin
            sb.flag_error($sformatf("%0d search results never arrived", sb.expected_q.size()));
        end
        $display("Sent %0d option bytes in %0d packets across seven register settings,",
                 bytes_sent, packets_sent);
        $display("checked %0d search results (%0d found), %0d mismatches.",
                 sb.n_results, sb.n_found, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("dhcp_option_tlv_scanner_tb: clean");
        end else begin
            $display("dhcp_option_tlv_scanner_tb: errors");
        end
        $finish;
    end

endmodule
